// File: rtl/pfr_pkg.sv
package pfr_pkg;

    localparam int FRAMES     = 2048;
    localparam int PAGE_BITS  = 19;
    localparam int TIME_BITS  = 32;

    localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W      = $clog2(FRAMES + 1);

    localparam int ADDR_W     = 32;
    localparam int POLICY_W   = 1;
    localparam int PSZ_W      = 6;
    localparam int FC_W       = 12;
    localparam int PER_W      = 8;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int SHIFT_W    = 4;
    localparam int SHIFT_BASE = 10;
    localparam int CLS_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE_KB = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PERIOD   = 2'd3;

    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_NRU = 1'b1;

    localparam logic [CLS_W-1:0] CLS_NONE = 3'd4;

    localparam logic [PSZ_W-1:0] RST_PAGE_SIZE_KB = 6'd8;
    localparam logic [FC_W-1:0]  RST_FRAME_COUNT  = 12'd2048;
    localparam logic [PER_W-1:0] RST_REF_PERIOD   = 8'd10;

    typedef struct packed {
        logic              policy;
        logic [PSZ_W-1:0]  page_size_kb;
        logic [FC_W-1:0]   frame_count;
        logic [PER_W-1:0]  ref_clear_period;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic clear_due;
        logic clear_last;
    } t_sts;

    function automatic logic [SHIFT_W-1:0] page_shift(input logic [PSZ_W-1:0] kb);
        logic [SHIFT_W-1:0] lg;
        lg = '0;
        for (int b = 1; b < PSZ_W; b++) begin
            if (kb[b]) begin
                lg = SHIFT_W'(b);
            end
        end
        return lg + SHIFT_W'(SHIFT_BASE);
    endfunction

    function automatic logic [CNT_W-1:0] frames_in_use(input logic [FC_W-1:0] fc);
        int v;
        v = int'(fc);
        if (v == 0) begin
            v = 1;
        end
        if (v > FRAMES) begin
            v = FRAMES;
        end
        return CNT_W'(v);
    endfunction

endpackage

// File: rtl/pfr_ctrl.sv
module pfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pfr_pkg::t_sts  i_sts,
    output pfr_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = i_sts.clear_due ? S_CLEAR : S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pfr_datapath.sv
module pfr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfr_pkg::t_cfg                     i_cfg,
    input  pfr_pkg::t_cmd                     i_cmd,
    output pfr_pkg::t_sts                     o_sts,
    input  logic [pfr_pkg::ADDR_W-1:0]        i_address,
    input  logic                              i_is_write,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_fault,
    output logic [pfr_pkg::FRAME_W-1:0]       o_frame,
    output logic                              o_evicted_valid,
    output logic [pfr_pkg::PAGE_BITS-1:0]     o_evicted_page,
    output logic                              o_evicted_dirty
);

    logic [pfr_pkg::PAGE_BITS-1:0] r_tag_mem [pfr_pkg::FRAMES];
    logic [pfr_pkg::TIME_BITS-1:0] r_use_mem [pfr_pkg::FRAMES];
    logic                          r_ref_mem [pfr_pkg::FRAMES];
    logic                          r_mod_mem [pfr_pkg::FRAMES];

    logic [pfr_pkg::PAGE_BITS-1:0] r_tag_q;
    logic [pfr_pkg::TIME_BITS-1:0] r_use_q;
    logic                          r_ref_q;
    logic                          r_mod_q;

    logic [pfr_pkg::PAGE_BITS-1:0] r_page;
    logic                          r_wr;
    logic [pfr_pkg::CNT_W-1:0]     r_n;
    logic [pfr_pkg::CNT_W-1:0]     r_lim;
    logic [pfr_pkg::CNT_W-1:0]     r_filled;
    logic [pfr_pkg::TIME_BITS-1:0] r_time;
    logic [pfr_pkg::PER_W-1:0]     r_pc;
    logic [pfr_pkg::CNT_W-1:0]     r_scan_idx;
    logic [pfr_pkg::FRAME_W-1:0]   r_clr_idx;

    logic                          r_p1_valid;
    logic [pfr_pkg::FRAME_W-1:0]   r_p1_idx;

    logic                          r_p2_valid;
    logic [pfr_pkg::FRAME_W-1:0]   r_p2_idx;
    logic                          r_p2_match;
    logic [pfr_pkg::TIME_BITS-1:0] r_p2_age;
    logic [pfr_pkg::CLS_W-1:0]     r_p2_cls;
    logic [pfr_pkg::PAGE_BITS-1:0] r_p2_tag;
    logic                          r_p2_mod;

    logic                          r_hit;
    logic [pfr_pkg::FRAME_W-1:0]   r_hit_idx;
    logic [pfr_pkg::FRAME_W-1:0]   r_best_idx;
    logic [pfr_pkg::TIME_BITS-1:0] r_best_age;
    logic [pfr_pkg::CLS_W-1:0]     r_best_cls;
    logic [pfr_pkg::PAGE_BITS-1:0] r_best_tag;
    logic                          r_best_mod;

    logic                          r_out_valid;
    logic                          r_fault;
    logic [pfr_pkg::FRAME_W-1:0]   r_frame;
    logic                          r_ev_valid;
    logic [pfr_pkg::PAGE_BITS-1:0] r_ev_page;
    logic                          r_ev_dirty;

    logic [pfr_pkg::ADDR_W-1:0]    addr_shifted;
    logic [pfr_pkg::CNT_W-1:0]     n_fiu;
    logic                          issue;
    logic                          full;
    logic                          evict;
    logic [pfr_pkg::FRAME_W-1:0]   slot;
    logic [pfr_pkg::FRAME_W-1:0]   wr_addr;
    logic [pfr_pkg::FRAME_W-1:0]   rd_addr;
    logic [pfr_pkg::PER_W-1:0]     period;
    logic [pfr_pkg::PER_W-1:0]     pc_inc;
    logic                          clear_due;
    logic                          better;

    always_comb begin
        addr_shifted = i_address >> pfr_pkg::page_shift(i_cfg.page_size_kb);
        n_fiu        = pfr_pkg::frames_in_use(i_cfg.frame_count);
        issue        = i_cmd.scan && (r_scan_idx < r_lim);
        rd_addr      = r_scan_idx[pfr_pkg::FRAME_W-1:0];
        full         = (r_filled >= r_n);
        evict        = !r_hit && full;
        if (r_hit) begin
            slot = r_hit_idx;
        end else if (full) begin
            slot = r_best_idx;
        end else begin
            slot = r_filled[pfr_pkg::FRAME_W-1:0];
        end
        wr_addr   = i_cmd.clear ? r_clr_idx : slot;
        period    = (i_cfg.ref_clear_period == '0) ? pfr_pkg::PER_W'(1)
                                                   : i_cfg.ref_clear_period;
        pc_inc    = r_pc + pfr_pkg::PER_W'(1);
        clear_due = (pc_inc >= period);
        if (i_cfg.policy == pfr_pkg::POLICY_LRU) begin
            better = (r_p2_idx == '0) || (r_p2_age > r_best_age);
        end else begin
            better = (r_p2_cls < r_best_cls);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_hit) begin
            r_tag_mem[wr_addr] <= r_page;
        end
        r_tag_q <= r_tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_use_mem[wr_addr] <= r_time;
        end
        r_use_q <= r_use_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update || i_cmd.clear) begin
            r_ref_mem[wr_addr] <= i_cmd.update;
        end
        r_ref_q <= r_ref_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && (!r_hit || r_wr)) begin
            r_mod_mem[wr_addr] <= r_wr;
        end
        r_mod_q <= r_mod_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled    <= '0;
            r_time      <= '0;
            r_pc        <= '0;
            r_scan_idx  <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_idx <= '0;
            end else if (issue) begin
                r_scan_idx <= r_scan_idx + pfr_pkg::CNT_W'(1);
            end
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
            if (i_cmd.update) begin
                if (!r_hit && !full) begin
                    r_filled <= r_filled + pfr_pkg::CNT_W'(1);
                end
                r_time <= r_time + pfr_pkg::TIME_BITS'(1);
                r_pc   <= clear_due ? '0 : pc_inc;
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page     <= addr_shifted[pfr_pkg::PAGE_BITS-1:0];
            r_wr       <= i_is_write;
            r_n        <= n_fiu;
            r_lim      <= (r_filled < n_fiu) ? r_filled : n_fiu;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_best_idx <= '0;
            r_best_age <= '0;
            r_best_cls <= pfr_pkg::CLS_NONE;
            r_best_tag <= '0;
            r_best_mod <= 1'b0;
        end else if (r_p2_valid) begin
            if (r_p2_match && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_p2_idx;
            end
            if (better) begin
                r_best_idx <= r_p2_idx;
                r_best_age <= r_p2_age;
                r_best_cls <= r_p2_cls;
                r_best_tag <= r_p2_tag;
                r_best_mod <= r_p2_mod;
            end
        end

        r_p1_idx   <= rd_addr;
        r_p2_idx   <= r_p1_idx;
        r_p2_match <= (r_tag_q == r_page);
        r_p2_age   <= r_time - r_use_q;
        r_p2_cls   <= {1'b0, r_ref_q, r_mod_q};
        r_p2_tag   <= r_tag_q;
        r_p2_mod   <= r_mod_q;

        if (i_cmd.update) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + pfr_pkg::FRAME_W'(1);
        end

        if (i_cmd.update) begin
            r_fault    <= !r_hit;
            r_frame    <= slot;
            r_ev_valid <= evict;
            r_ev_page  <= evict ? r_best_tag : '0;
            r_ev_dirty <= evict ? r_best_mod : 1'b0;
        end
    end

    always_comb begin
        o_sts.scan_done  = (r_scan_idx >= r_lim) && !r_p1_valid && !r_p2_valid;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.clear_due  = clear_due;
        o_sts.clear_last = (r_clr_idx == pfr_pkg::FRAME_W'(pfr_pkg::FRAMES - 1));
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_fault;
    assign o_frame         = r_frame;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_evicted_dirty = r_ev_dirty;

endmodule

// File: rtl/page_frame_replacement.sv
// Flow: an accepted access starts a scan of min(filled, frames in use) frames of the frame table,
// one frame read per cycle; once the scan is done and the output register is free, the result is
// registered, and only then is the next access accepted. After every ref_clear_period accesses,
// a referenced-bit clearing pass over all 2048 frames runs before the next access is accepted.
// Reset is synchronous and active low: it restores the configuration defaults and clears
// control state and counters; the frame memories are not cleared and no pass runs after it.
module page_frame_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfr_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pfr_pkg::ADDR_W-1:0]        i_address,
    input  logic                              i_is_write,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_fault,
    output logic [pfr_pkg::FRAME_W-1:0]       o_frame,
    output logic                              o_evicted_valid,
    output logic [pfr_pkg::PAGE_BITS-1:0]     o_evicted_page,
    output logic                              o_evicted_dirty
);

    pfr_pkg::t_cfg r_cfg;
    pfr_pkg::t_cmd cmd;
    pfr_pkg::t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy           <= pfr_pkg::POLICY_LRU;
            r_cfg.page_size_kb     <= pfr_pkg::RST_PAGE_SIZE_KB;
            r_cfg.frame_count      <= pfr_pkg::RST_FRAME_COUNT;
            r_cfg.ref_clear_period <= pfr_pkg::RST_REF_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pfr_pkg::CFG_POLICY: begin
                    r_cfg.policy <= i_cfg_data[0];
                end
                pfr_pkg::CFG_PAGE_SIZE_KB: begin
                    r_cfg.page_size_kb <= i_cfg_data[pfr_pkg::PSZ_W-1:0];
                end
                pfr_pkg::CFG_FRAME_COUNT: begin
                    r_cfg.frame_count <= i_cfg_data[pfr_pkg::FC_W-1:0];
                end
                pfr_pkg::CFG_REF_PERIOD: begin
                    r_cfg.ref_clear_period <= i_cfg_data[pfr_pkg::PER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    pfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_address       (i_address),
        .i_is_write      (i_is_write),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fault         (o_fault),
        .o_frame         (o_frame),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_evicted_dirty (o_evicted_dirty)
    );

endmodule

// File: verif/tb.sv
module tb;

    import pfr_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int PASS_WAIT       = FRAMES + 64;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int POOL_MAX        = 24;

    localparam bit [CFG_W-1:0] PHASE_PAGE_KB [RANDOM_PHASES] = '{8, 16, 32, 1, 0, 63, 8, 12};
    localparam bit [CFG_W-1:0] PHASE_FRAMES  [RANDOM_PHASES] = '{4, 2, 8, 1, 16, 3, 2048, 5};
    localparam bit [CFG_W-1:0] PHASE_PERIOD  [RANDOM_PHASES] = '{10, 1, 255, 3, 0, 2, 7, 1};

    typedef struct packed {
        logic                 fault;
        logic [FRAME_W-1:0]   frame;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 evicted_dirty;
    } t_result;

    typedef enum bit {ROW_ACCESS, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [ADDR_W-1:0]    address;
        logic                 is_write;
        logic                 known;
        t_result              want;
    } t_row;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [ADDR_W-1:0]    i_address = '0;
    logic                 i_is_write = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_fault;
    logic [FRAME_W-1:0]   o_frame;
    logic                 o_evicted_valid;
    logic [PAGE_BITS-1:0] o_evicted_page;
    logic                 o_evicted_dirty;

    // Mirror of the frame table and its bookkeeping.
    bit [PAGE_BITS-1:0] frame_page  [FRAMES];
    bit [TIME_BITS-1:0] frame_stamp [FRAMES];
    bit                 frame_ref   [FRAMES];
    bit                 frame_dirty [FRAMES];
    int                 frames_filled = 0;
    bit [TIME_BITS-1:0] now_stamp = '0;
    bit [PER_W-1:0]     since_clear = '0;

    bit                 cur_policy = POLICY_LRU;
    bit [PSZ_W-1:0]     cur_page_kb = RST_PAGE_SIZE_KB;
    bit [FC_W-1:0]      cur_frame_count = RST_FRAME_COUNT;
    bit [PER_W-1:0]     cur_clear_period = RST_REF_PERIOD;

    t_result            expected_outcomes [$];
    int                 mismatch_count = 0;
    int                 tx_idle_pct = 0;
    int                 rx_stall_pct = 0;
    int                 quiet_cycles = 0;

    page_frame_replacement uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_address       (i_address),
        .i_is_write      (i_is_write),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fault         (o_fault),
        .o_frame         (o_frame),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_evicted_dirty (o_evicted_dirty)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int shift_for_size(input bit [PSZ_W-1:0] kb);
        int lg;
        bit [PSZ_W-1:0] v;
        lg = 0;
        v = kb;
        while (v > 1) begin
            v = v >> 1;
            lg++;
        end
        return lg + SHIFT_BASE;
    endfunction

    function automatic int frames_active();
        int n;
        n = int'(cur_frame_count);
        if (n == 0) begin
            n = 1;
        end
        if (n > FRAMES) begin
            n = FRAMES;
        end
        return n;
    endfunction

    function automatic t_result resolve_access(input bit [ADDR_W-1:0] addr, input bit wr);
        t_result r;
        bit [PAGE_BITS-1:0] page;
        bit [TIME_BITS-1:0] age;
        bit [TIME_BITS-1:0] best_age;
        int n;
        int searched;
        int slot;
        int cls;
        int best_cls;
        int period;
        bit hit;
        r = '0;
        hit = 1'b0;
        slot = 0;
        page = PAGE_BITS'(addr >> shift_for_size(cur_page_kb));
        n = frames_active();
        searched = (frames_filled < n) ? frames_filled : n;
        for (int i = 0; i < searched; i++) begin
            if (!hit && frame_page[i] == page) begin
                hit = 1'b1;
                slot = i;
            end
        end
        if (hit) begin
            frame_stamp[slot] = now_stamp;
            frame_ref[slot] = 1'b1;
            if (wr) begin
                frame_dirty[slot] = 1'b1;
            end
        end else begin
            r.fault = 1'b1;
            if (frames_filled < n) begin
                slot = frames_filled;
                frames_filled++;
            end else begin
                if (cur_policy == POLICY_LRU) begin
                    best_age = '0;
                    for (int i = 0; i < n; i++) begin
                        age = now_stamp - frame_stamp[i];
                        if (i == 0 || age > best_age) begin
                            best_age = age;
                            slot = i;
                        end
                    end
                end else begin
                    best_cls = 4;
                    for (int i = 0; i < n; i++) begin
                        cls = 2 * int'(frame_ref[i]) + int'(frame_dirty[i]);
                        if (cls < best_cls) begin
                            best_cls = cls;
                            slot = i;
                        end
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_page[slot];
                r.evicted_dirty = frame_dirty[slot];
            end
            frame_page[slot] = page;
            frame_stamp[slot] = now_stamp;
            frame_ref[slot] = 1'b1;
            frame_dirty[slot] = wr;
        end
        now_stamp = now_stamp + 1'b1;
        period = (cur_clear_period == 0) ? 1 : int'(cur_clear_period);
        since_clear = since_clear + 1'b1;
        if (int'(since_clear) >= period) begin
            frame_ref = '{default: 1'b0};
            since_clear = '0;
        end
        r.frame = FRAME_W'(slot);
        return r;
    endfunction

    function automatic t_row row_access(input bit [ADDR_W-1:0] addr, input bit wr);
        t_row row;
        row = '0;
        row.kind = ROW_ACCESS;
        row.address = addr;
        row.is_write = wr;
        return row;
    endfunction

    function automatic t_row row_known(input bit [ADDR_W-1:0] addr, input bit wr,
                                       input bit f, input int fr, input bit ev,
                                       input int ev_page, input bit ev_dirty);
        t_row row;
        row = row_access(addr, wr);
        row.known = 1'b1;
        row.want.fault = f;
        row.want.frame = FRAME_W'(fr);
        row.want.evicted_valid = ev;
        row.want.evicted_page = PAGE_BITS'(ev_page);
        row.want.evicted_dirty = ev_dirty;
        return row;
    endfunction

    function automatic t_row row_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input bit [CFG_W-1:0] val);
        t_row row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        tx_idle_pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 29 : 0;
        rx_stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 29 : 0;
    endtask

    // The sender holds off until every expected result is back, then lets a full
    // referenced-bit clearing pass finish before anything else happens.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PASS_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [CFG_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_POLICY:       cur_policy = val[0];
            CFG_PAGE_SIZE_KB: cur_page_kb = val[PSZ_W-1:0];
            CFG_FRAME_COUNT:  cur_frame_count = val[FC_W-1:0];
            CFG_REF_PERIOD:   cur_clear_period = val[PER_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic offer_access(input bit [ADDR_W-1:0] addr, input bit wr,
                                input bit known, input t_result want);
        t_result predicted;
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_address <= addr;
        i_is_write <= wr;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        predicted = resolve_access(addr, wr);
        expected_outcomes.push_back(known ? want : predicted);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            got = {o_fault, o_frame, o_evicted_valid, o_evicted_page, o_evicted_dirty};
            if (expected_outcomes.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want = expected_outcomes.pop_front();
                if (got.fault !== want.fault) begin
                    $error("fault: expected %0d, got %0d", want.fault, got.fault);
                    mismatch_count++;
                end
                if (got.frame !== want.frame) begin
                    $error("frame: expected %0d, got %0d", want.frame, got.frame);
                    mismatch_count++;
                end
                if (got.evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.evicted_valid, got.evicted_valid);
                    mismatch_count++;
                end
                if (got.evicted_page !== want.evicted_page) begin
                    $error("evicted_page: expected 0x%0h, got 0x%0h",
                           want.evicted_page, got.evicted_page);
                    mismatch_count++;
                end
                if (got.evicted_dirty !== want.evicted_dirty) begin
                    $error("evicted_dirty: expected %0d, got %0d",
                           want.evicted_dirty, got.evicted_dirty);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row directed_rows [$];
        bit [ADDR_W-1:0] page_bases [$];
        bit [ADDR_W-1:0] low_mask;
        bit [ADDR_W-1:0] addr;
        bit cfg_open;
        int pool;

        cfg_open = 1'b0;
        directed_rows = '{
            row_known(32'h0000_0000, 1'b0, 1'b1, 0, 1'b0, 0, 1'b0),
            row_known(32'h0000_1FFF, 1'b1, 1'b0, 0, 1'b0, 0, 1'b0),
            row_known(32'hFFFF_FFFF, 1'b1, 1'b1, 1, 1'b0, 0, 1'b0),
            row_known(32'h0000_2000, 1'b0, 1'b1, 2, 1'b0, 0, 1'b0),
            row_reg(CFG_FRAME_COUNT, 12'd3),
            row_known(32'h0000_4000, 1'b1, 1'b1, 0, 1'b1, 0, 1'b1),
            row_access(32'h0000_2ABC, 1'b1),
            row_reg(CFG_POLICY, CFG_W'(POLICY_NRU)),
            row_reg(CFG_REF_PERIOD, 12'd0),
            row_access(32'h0000_6000, 1'b0),
            row_access(32'hFFFF_E000, 1'b0),
            row_access(32'h0000_8000, 1'b1),
            row_reg(CFG_PAGE_SIZE_KB, 12'd0),
            row_access(32'h0000_0400, 1'b1),
            row_access(32'h0000_07FF, 1'b0),
            row_reg(CFG_PAGE_SIZE_KB, 12'd63),
            row_access(32'h8000_0000, 1'b1),
            row_access(32'h7FFF_FFFF, 1'b0),
            row_reg(CFG_PAGE_SIZE_KB, 12'hFC1),
            row_reg(CFG_FRAME_COUNT, 12'd0),
            row_reg(CFG_POLICY, CFG_W'(POLICY_LRU)),
            row_access(32'h0001_2345, 1'b0),
            row_access(32'h0000_0000, 1'b1),
            row_access(32'hAAAA_A000, 1'b0),
            row_reg(CFG_FRAME_COUNT, 12'hFFF),
            row_reg(CFG_REF_PERIOD, 12'd255),
            row_reg(CFG_PAGE_SIZE_KB, 12'd32),
            row_access(32'h5555_5555, 1'b1),
            row_access(32'hAAAA_AAAA, 1'b0),
            row_access(32'h5555_4000, 1'b0)
        };

        set_idling(IDLE_NONE);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                if (!cfg_open) begin
                    settle_block();
                    cfg_open = 1'b1;
                end
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                offer_access(directed_rows[k].address, directed_rows[k].is_write,
                             directed_rows[k].known, directed_rows[k].want);
            end
        end

        // Each phase draws from a small set of pages so that hits and evictions dominate,
        // with an occasional address from anywhere.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle_block();
            write_reg(CFG_POLICY, CFG_W'(p[1]));
            write_reg(CFG_PAGE_SIZE_KB, PHASE_PAGE_KB[p]);
            write_reg(CFG_FRAME_COUNT, PHASE_FRAMES[p]);
            write_reg(CFG_REF_PERIOD, PHASE_PERIOD[p]);
            i_cfg_we <= 1'b0;
            set_idling(t_idle_mode'(p % 4));
            low_mask = (32'h1 << shift_for_size(cur_page_kb)) - 1;
            pool = frames_active() + 2;
            if (pool > POOL_MAX) begin
                pool = POOL_MAX;
            end
            page_bases.delete();
            repeat (pool) page_bases.push_back($urandom & ~low_mask);
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(7) == 0) begin
                    addr = $urandom;
                end else begin
                    addr = page_bases[$urandom_range(pool - 1)] | ($urandom & low_mask);
                end
                offer_access(addr, 1'($urandom_range(1)), 1'b0, '0);
            end
        end

        settle_block();
        if (expected_outcomes.size() != 0) begin
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
